// File: rtl/tqpr_pkg.sv
// Shared constants for the two-queue page replacer.
package tqpr_pkg;

    // Default number of buffer frames tracked.
    localparam int FRAMES_DEFAULT = 64;

    // Fixed payload widths.
    localparam int FUNC_W  = 2;
    localparam int FRAME_W = 6;
    localparam int COUNT_W = 7;

    // Operation codes carried in the func field.
    localparam logic [FUNC_W-1:0] FUNC_VICTIM = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PIN    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_UNPIN  = 2'd2;

    // List selectors.
    localparam logic LIST_COLD = 1'b0;
    localparam logic LIST_HOT  = 1'b1;

endpackage

// File: rtl/tqpr_req_if.sv
// Request channel interface: operation code and frame index.
interface tqpr_req_if;
    logic                          valid;
    logic                          ready;
    logic [tqpr_pkg::FUNC_W-1:0]   func;
    logic [tqpr_pkg::FRAME_W-1:0]  frame;

    modport source (output valid, output func, output frame, input ready);
    modport sink   (input valid, input func, input frame, output ready);
endinterface

// File: rtl/tqpr_rsp_if.sv
// Response channel interface: victim result and list counts.
interface tqpr_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          victim_found;
    logic [tqpr_pkg::FRAME_W-1:0]  victim_frame;
    logic [tqpr_pkg::COUNT_W-1:0]  evictable_count;
    logic [tqpr_pkg::COUNT_W-1:0]  cold_count;
    logic [tqpr_pkg::COUNT_W-1:0]  hot_count;

    modport source (output valid, output victim_found, output victim_frame,
                    output evictable_count, output cold_count, output hot_count,
                    input ready);
    modport sink   (input valid, input victim_found, input victim_frame,
                    input evictable_count, input cold_count, input hot_count,
                    output ready);
endinterface

// File: rtl/tqpr_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
module tqpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write first in program order does not matter: read returns old data on a collision.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/two_queue_page_replacer.sv
// Two-queue (FIFO cold list, LRU hot list) page replacer with linked lists in RAM.
//
//  Channel | Direction | Beat contents
//  --------+-----------+---------------------------------------------------------
//  req     | in        | func (victim, pin, unpin), frame
//  rsp     | out       | victim_found, victim_frame, evictable/cold/hot counts
//
// Each frame owns one RAM word {tracked, hot, pinned, next, prev}; every link
// update is a read-modify-write of that word, one word at a time.
// Pin runs fetch and examine; unpin adds a read and write per neighbor relinked and a
// self write; victim repeats fetch and examine per list entry, then relinks (no walk
// when nothing is evictable); the single RAM port and the tail-to-head walk set this order.
// After reset the block clears the tracked bits of all frames before req.ready.
// A finished beat waits in the output register; the next request is taken meanwhile.
module two_queue_page_replacer #(
    parameter int FRAMES = tqpr_pkg::FRAMES_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    tqpr_req_if.sink  req,
    tqpr_rsp_if.source rsp
);

    localparam int IW    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW    = $clog2(FRAMES + 1);
    localparam int WW    = 3 + 2 * IW;
    localparam int CNT_W = tqpr_pkg::COUNT_W;
    localparam int FRM_W = tqpr_pkg::FRAME_W;

    // Word bit positions.
    localparam int B_TRK = WW - 1;
    localparam int B_HOT = WW - 2;
    localparam int B_PIN = WW - 3;

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_FETCH  = 8'b0000_0100,
        S_EXAM   = 8'b0000_1000,
        S_FIX_RD = 8'b0001_0000,
        S_FIX_WR = 8'b0010_0000,
        S_SELF   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t                 state_reg, state_next;
    logic [IW-1:0]          clr_reg, clr_next;
    logic [FRM_W-1:0]       unused_frame;
    logic [tqpr_pkg::FUNC_W-1:0] op_reg, op_next;
    logic [IW-1:0]          cur_reg, cur_next;
    logic [CW-1:0]          left_reg, left_next;
    logic                   lsel_reg, lsel_next;
    logic [IW-1:0]          head_reg [2];
    logic [IW-1:0]          head_next [2];
    logic [IW-1:0]          tail_reg [2];
    logic [IW-1:0]          tail_next [2];
    logic [CW-1:0]          len_reg [2];
    logic [CW-1:0]          len_next [2];
    logic [CW-1:0]          cold_cnt_reg, cold_cnt_next;
    logic [CW-1:0]          hot_cnt_reg, hot_cnt_next;
    logic                   pjob_reg, pjob_next;
    logic                   njob_reg, njob_next;
    logic                   hjob_reg, hjob_next;
    logic [IW-1:0]          p_addr_reg, p_addr_next;
    logic [IW-1:0]          p_val_reg, p_val_next;
    logic [IW-1:0]          n_addr_reg, n_addr_next;
    logic [IW-1:0]          n_val_reg, n_val_next;
    logic [IW-1:0]          h_addr_reg, h_addr_next;
    logic [WW-1:0]          self_reg, self_next;
    logic                   found_reg, found_next;
    logic                   ovalid_reg, ovalid_next;
    logic                   ofound_reg, ofound_next;
    logic [FRM_W-1:0]       oframe_reg, oframe_next;
    logic [CNT_W-1:0]       oevict_reg, oevict_next;
    logic [CNT_W-1:0]       ocold_reg, ocold_next;
    logic [CNT_W-1:0]       ohot_reg, ohot_next;

    logic                   ram_we;
    logic [IW-1:0]          ram_waddr;
    logic [WW-1:0]          ram_wdata;
    logic [IW-1:0]          ram_raddr;
    logic [WW-1:0]          rdata;

    logic                   d_trk, d_hot, d_pin;
    logic [IW-1:0]          d_nxt, d_prv;
    logic [IW-1:0]          job_addr;
    logic                   frame_ok;

    assign d_trk = rdata[B_TRK];
    assign d_hot = rdata[B_HOT];
    assign d_pin = rdata[B_PIN];
    assign d_nxt = rdata[2*IW-1:IW];
    assign d_prv = rdata[IW-1:0];

    assign unused_frame = req.frame;
    assign frame_ok = (32'(unused_frame) < FRAMES);

    // Pending neighbor fix in priority order.
    assign job_addr = pjob_reg ? p_addr_reg : (njob_reg ? n_addr_reg : h_addr_reg);

    assign req.ready           = (state_reg == S_IDLE);
    assign rsp.valid           = ovalid_reg;
    assign rsp.victim_found    = ofound_reg;
    assign rsp.victim_frame    = oframe_reg;
    assign rsp.evictable_count = oevict_reg;
    assign rsp.cold_count      = ocold_reg;
    assign rsp.hot_count       = ohot_reg;

    tqpr_ram #(
        .WIDTH (WW),
        .DEPTH (FRAMES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    // Sequencer next-state and datapath.
    always_comb
    begin
        logic           l;
        logic           head_is;
        logic           tail_is;
        logic [CW-1:0]  len1a;
        logic [IW-1:0]  head1a;
        logic [IW-1:0]  nxt;
        logic [WW-1:0]  fixw;

        state_next    = state_reg;
        clr_next      = clr_reg;
        op_next       = op_reg;
        cur_next      = cur_reg;
        left_next     = left_reg;
        lsel_next     = lsel_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        len_next      = len_reg;
        cold_cnt_next = cold_cnt_reg;
        hot_cnt_next  = hot_cnt_reg;
        pjob_next     = pjob_reg;
        njob_next     = njob_reg;
        hjob_next     = hjob_reg;
        p_addr_next   = p_addr_reg;
        p_val_next    = p_val_reg;
        n_addr_next   = n_addr_reg;
        n_val_next    = n_val_reg;
        h_addr_next   = h_addr_reg;
        self_next     = self_reg;
        found_next    = found_reg;
        ovalid_next   = ovalid_reg;
        ofound_next   = ofound_reg;
        oframe_next   = oframe_reg;
        oevict_next   = oevict_reg;
        ocold_next    = ocold_reg;
        ohot_next     = ohot_reg;

        ram_we    = 1'b0;
        ram_waddr = cur_reg;
        ram_wdata = self_reg;
        ram_raddr = cur_reg;

        l       = tqpr_pkg::LIST_COLD;
        head_is = 1'b0;
        tail_is = 1'b0;
        len1a   = '0;
        head1a  = '0;
        nxt     = '0;
        fixw    = rdata;

        if (rsp.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + IW'(1);
                if (clr_reg == IW'(FRAMES - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.func;
                    found_next = 1'b0;
                    cur_next   = IW'(req.frame);
                    state_next = S_DONE;
                    case (req.func)
                        tqpr_pkg::FUNC_VICTIM:
                        begin
                            lsel_next = (cold_cnt_reg != '0) ? tqpr_pkg::LIST_COLD
                                                             : tqpr_pkg::LIST_HOT;
                            cur_next  = tail_reg[lsel_next];
                            left_next = len_reg[lsel_next];
                            if ((cold_cnt_reg != '0 || hot_cnt_reg != '0) &&
                                len_reg[lsel_next] != '0)
                            begin
                                state_next = S_FETCH;
                            end
                        end
                        tqpr_pkg::FUNC_PIN,
                        tqpr_pkg::FUNC_UNPIN:
                        begin
                            if (frame_ok)
                            begin
                                state_next = S_FETCH;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_FETCH:
            begin
                ram_raddr  = cur_reg;
                state_next = S_EXAM;
            end

            S_EXAM:
            begin
                pjob_next  = 1'b0;
                njob_next  = 1'b0;
                hjob_next  = 1'b0;
                state_next = S_DONE;
                case (op_reg)
                    tqpr_pkg::FUNC_PIN:
                    begin
                        // Mark pinned; the frame stays in its list.
                        if (d_trk && !d_pin)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = cur_reg;
                            fixw[B_PIN] = 1'b1;
                            ram_wdata = fixw;
                            if (d_hot)
                            begin
                                hot_cnt_next = hot_cnt_reg - CW'(1);
                            end
                            else
                            begin
                                cold_cnt_next = cold_cnt_reg - CW'(1);
                            end
                        end
                    end

                    tqpr_pkg::FUNC_UNPIN:
                    begin
                        if (!d_trk)
                        begin
                            // New cold frame at the FIFO front.
                            if (len_reg[0] == '0)
                            begin
                                tail_next[0] = cur_reg;
                                nxt          = cur_reg;
                            end
                            else
                            begin
                                nxt         = head_reg[0];
                                hjob_next   = 1'b1;
                                h_addr_next = head_reg[0];
                            end
                            head_next[0]  = cur_reg;
                            len_next[0]   = len_reg[0] + CW'(1);
                            cold_cnt_next = cold_cnt_reg + CW'(1);
                            self_next     = {1'b1, 1'b0, 1'b0, nxt, cur_reg};
                        end
                        else
                        begin
                            // Unlink from its list, then push to the LRU front.
                            l       = d_hot;
                            head_is = (head_reg[l] == cur_reg);
                            tail_is = (tail_reg[l] == cur_reg);
                            head_next[l] = head_is ? d_nxt : head_reg[l];
                            tail_next[l] = tail_is ? d_prv : tail_reg[l];
                            len_next[l]  = len_reg[l] - CW'(1);
                            pjob_next    = !head_is;
                            p_addr_next  = d_prv;
                            p_val_next   = d_nxt;
                            njob_next    = !tail_is;
                            n_addr_next  = d_nxt;
                            n_val_next   = d_prv;
                            len1a  = len_next[1];
                            head1a = head_next[1];
                            if (len1a == '0)
                            begin
                                tail_next[1] = cur_reg;
                                nxt          = cur_reg;
                            end
                            else
                            begin
                                nxt         = head1a;
                                hjob_next   = 1'b1;
                                h_addr_next = head1a;
                            end
                            head_next[1] = cur_reg;
                            len_next[1]  = len1a + CW'(1);
                            if (!d_hot && !d_pin)
                            begin
                                cold_cnt_next = cold_cnt_reg - CW'(1);
                                hot_cnt_next  = hot_cnt_reg + CW'(1);
                            end
                            else if (d_pin)
                            begin
                                hot_cnt_next = hot_cnt_reg + CW'(1);
                            end
                            self_next = {1'b1, 1'b1, 1'b0, nxt, cur_reg};
                        end
                        state_next = S_SELF;
                        if (pjob_next || njob_next || hjob_next)
                        begin
                            state_next = S_FIX_RD;
                        end
                    end

                    tqpr_pkg::FUNC_VICTIM:
                    begin
                        if (32'(cur_reg) >= FRAMES)
                        begin
                            state_next = S_DONE;
                        end
                        else if (d_hot == lsel_reg && !d_pin)
                        begin
                            // Oldest evictable entry: unlink and drop it.
                            l       = lsel_reg;
                            head_is = (head_reg[l] == cur_reg);
                            tail_is = (tail_reg[l] == cur_reg);
                            head_next[l] = head_is ? d_nxt : head_reg[l];
                            tail_next[l] = tail_is ? d_prv : tail_reg[l];
                            len_next[l]  = len_reg[l] - CW'(1);
                            pjob_next    = !head_is;
                            p_addr_next  = d_prv;
                            p_val_next   = d_nxt;
                            njob_next    = !tail_is;
                            n_addr_next  = d_nxt;
                            n_val_next   = d_prv;
                            if (l == tqpr_pkg::LIST_COLD)
                            begin
                                cold_cnt_next = cold_cnt_reg - CW'(1);
                            end
                            else
                            begin
                                hot_cnt_next = hot_cnt_reg - CW'(1);
                            end
                            fixw[B_TRK] = 1'b0;
                            self_next   = fixw;
                            found_next  = 1'b1;
                            state_next  = (pjob_next || njob_next) ? S_FIX_RD : S_SELF;
                        end
                        else if (left_reg == CW'(1))
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            left_next  = left_reg - CW'(1);
                            cur_next   = d_prv;
                            state_next = S_FETCH;
                        end
                    end

                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_FIX_RD:
            begin
                ram_raddr  = job_addr;
                state_next = S_FIX_WR;
            end

            S_FIX_WR:
            begin
                // Patch one link of a neighbor word.
                ram_we    = 1'b1;
                ram_waddr = job_addr;
                if (pjob_reg)
                begin
                    fixw[2*IW-1:IW] = p_val_reg;
                    pjob_next = 1'b0;
                end
                else if (njob_reg)
                begin
                    fixw[IW-1:0] = n_val_reg;
                    njob_next = 1'b0;
                end
                else
                begin
                    fixw[IW-1:0] = cur_reg;
                    hjob_next = 1'b0;
                end
                ram_wdata  = fixw;
                state_next = (pjob_next || njob_next || hjob_next) ? S_FIX_RD : S_SELF;
            end

            S_SELF:
            begin
                ram_we     = 1'b1;
                ram_waddr  = cur_reg;
                ram_wdata  = self_reg;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // Load the result beat once the output register is free.
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next = 1'b1;
                    ofound_next = found_reg;
                    oframe_next = found_reg ? FRM_W'(cur_reg) : '0;
                    oevict_next = CNT_W'(cold_cnt_reg + hot_cnt_reg);
                    ocold_next  = CNT_W'(cold_cnt_reg);
                    ohot_next   = CNT_W'(hot_cnt_reg);
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            len_reg[0]   <= '0;
            len_reg[1]   <= '0;
            cold_cnt_reg <= '0;
            hot_cnt_reg  <= '0;
            pjob_reg     <= 1'b0;
            njob_reg     <= 1'b0;
            hjob_reg     <= 1'b0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            len_reg      <= len_next;
            cold_cnt_reg <= cold_cnt_next;
            hot_cnt_reg  <= hot_cnt_next;
            pjob_reg     <= pjob_next;
            njob_reg     <= njob_next;
            hjob_reg     <= hjob_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        cur_reg     <= cur_next;
        left_reg    <= left_next;
        lsel_reg    <= lsel_next;
        head_reg    <= head_next;
        tail_reg    <= tail_next;
        p_addr_reg  <= p_addr_next;
        p_val_reg   <= p_val_next;
        n_addr_reg  <= n_addr_next;
        n_val_reg   <= n_val_next;
        h_addr_reg  <= h_addr_next;
        self_reg    <= self_next;
        found_reg   <= found_next;
        ofound_reg  <= ofound_next;
        oframe_reg  <= oframe_next;
        oevict_reg  <= oevict_next;
        ocold_reg   <= ocold_next;
        ohot_reg    <= ohot_next;
    end

`ifndef NO_ASSERTIONS
    // Unpinned cold frames never outnumber the cold list.
    a_cold_le_len: assert property (@(posedge clk) disable iff (!rst_n)
        cold_cnt_reg <= len_reg[0])
        else $error("cold count exceeds cold list length");

    // Unpinned hot frames never outnumber the hot list.
    a_hot_le_len: assert property (@(posedge clk) disable iff (!rst_n)
        hot_cnt_reg <= len_reg[1])
        else $error("hot count exceeds hot list length");

    // Both lists together never hold more than all frames.
    a_len_total: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(len_reg[0]) + 32'(len_reg[1])) <= FRAMES)
        else $error("list lengths exceed frame count");

    // A list word is examined only in the cycle after its read was issued.
    a_exam_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXAM) |-> ($past(state_reg) == S_FETCH))
        else $error("examine without a preceding fetch");

    // No victim means the reported frame is zero.
    a_no_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !ofound_reg) |-> (oframe_reg == '0))
        else $error("victim frame nonzero without a victim");
`endif

endmodule
